[sv/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

[sv/lws_pkg.sv]
package lws_pkg;

	localparam int IdxW = 10;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_QUERY  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		REG_MIN   = 2'd0,
		REG_MAX   = 2'd1,
		REG_SLOPE = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic [15:0]        speed;
	} in_item_t;

	typedef struct packed {
		logic [IdxW-1:0] lookahead_index;
		logic [IdxW-1:0] nearest_index;
		logic [15:0]     nearest_speed;
		logic            window_hit;
		logic            any_hit;
	} out_item_t;

	// one candidate beat from the distance pipeline
	typedef struct packed {
		logic        vld;
		logic        first;
		logic        last;
		logic [1:0]  pass;
		logic [63:0] dsq;
	} cand_t;

	localparam logic [1:0] PASS_WIN  = 2'd0;
	localparam logic [1:0] PASS_FULL = 2'd1;
	localparam logic [1:0] PASS_NEAR = 2'd2;

endpackage

[sv/lws_dist.sv]
// squared distance pipeline: sub, abs, square (split), sum with saturation
module lws_dist import lws_pkg::*; #(
	parameter int AW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld,
	input  logic               first,
	input  logic               last,
	input  logic [1:0]         pass,
	input  logic [AW-1:0]      idx,
	input  logic signed [31:0] px,
	input  logic signed [31:0] py,
	input  logic signed [31:0] cx,
	input  logic signed [31:0] cy,
	input  logic [15:0]        spd,
	output cand_t              cand,
	output logic [AW-1:0]      cand_idx,
	output logic [15:0]        cand_spd
);

	logic [3:0] vld_q;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [15:0] spd_s1, spd_s2, spd_s3, spd_s4;
	logic [3:0] ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [32:0] dx_s1, dy_s1;
	logic [31:0] ax_s2, ay_s2;
	logic [47:0] xl_s3, xh_s3, yl_s3, yh_s3;
	logic [63:0] sx_s4, sy_s4;
	logic signed [32:0] dxw, dyw;
	logic [64:0] sum;
	logic [63:0] sxw, syw;

	assign dxw = 33'(signed'(px)) - 33'(signed'(cx));
	assign dyw = 33'(signed'(py)) - 33'(signed'(cy));
	assign sxw = {16'd0, xh_s3} << 16;
	assign syw = {16'd0, yh_s3} << 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], vld};
		end
	end

	always_ff @(posedge clk) begin
		dx_s1  <= dxw;
		dy_s1  <= dyw;
		idx_s1 <= idx;
		spd_s1 <= spd;
		ctl_s1 <= {first, last, pass};
		ax_s2  <= dx_s1[32] ? 32'(-dx_s1) : dx_s1[31:0];
		ay_s2  <= dy_s1[32] ? 32'(-dy_s1) : dy_s1[31:0];
		idx_s2 <= idx_s1;
		spd_s2 <= spd_s1;
		ctl_s2 <= ctl_s1;
		xl_s3  <= 48'(ax_s2) * 48'(ax_s2[15:0]);
		xh_s3  <= 48'(ax_s2) * 48'(ax_s2[31:16]);
		yl_s3  <= 48'(ay_s2) * 48'(ay_s2[15:0]);
		yh_s3  <= 48'(ay_s2) * 48'(ay_s2[31:16]);
		idx_s3 <= idx_s2;
		spd_s3 <= spd_s2;
		ctl_s3 <= ctl_s2;
		sx_s4  <= sxw + 64'(xl_s3);
		sy_s4  <= syw + 64'(yl_s3);
		idx_s4 <= idx_s3;
		spd_s4 <= spd_s3;
		ctl_s4 <= ctl_s3;
	end

	assign sum = 65'(sx_s4) + 65'(sy_s4);

	always_comb begin
		cand.vld   = vld_q[3];
		cand.first = ctl_s4[3];
		cand.last  = ctl_s4[2];
		cand.pass  = ctl_s4[1:0];
		cand.dsq   = sum[64] ? '1 : sum[63:0];
	end
	assign cand_idx = idx_s4;
	assign cand_spd = spd_s4;

endmodule

[sv/lookahead_waypoint_search.sv]
// channel | direction | payload    | handshake
// in      | into      | in_item_t  | in_valid / in_stall
// out     | out of    | out_item_t | out_valid / out_stall
// cfg     | into      | index,data | cfg_valid / cfg_ready
// append and clear complete in ST_IDLE; a query on n waypoints runs a window pass over
// min(n, WINDOW) entries and a nearest pass over all n when the window finds a hit, with a
// full pass over n between them when it falls back, plus any output stall; each pass reads
// one entry per cycle, then drains through the table read and the 4-stage distance pipeline
// reset empties the table; no clearing pass, table contents stay undefined
// a stalled result holds in the output register; input stalls until taken
module lookahead_waypoint_search import lws_pkg::*; #(
	parameter int DEPTH  = 1024,
	parameter int WINDOW = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	`include "assert_macros.svh"

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] WIN_C = (WINDOW < DEPTH) ? CW'(WINDOW) : CW'(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_SCAN, ST_DRAIN, ST_OUT
	} state_t;

	state_t state_q;
	logic [23:0] min_q, max_q, slope_q;
	logic [CW-1:0] count_q, n_q, left_q;
	logic [AW-1:0] pos_q, rd_q, lai_q, nri_q;
	logic [1:0] pass_q;
	logic first_q;
	logic signed [31:0] cx_q, cy_q;
	logic [15:0] spd_q, nrs_q;
	logic [39:0] prod_q;
	logic [63:0] lasq_q, longest_q, shortest_q;
	logic whit_q, ahit_q;
	logic [32:0] la;
	logic [47:0] la_sq;
	logic [31:0] mem_x [DEPTH];
	logic [31:0] mem_y [DEPTH];
	logic [15:0] mem_s [DEPTH];
	logic [31:0] rx_s1, ry_s1;
	logic [15:0] rs_s1;
	logic rd_vld, rd_first, rd_last;
	logic rv_s1, rf_s1, rl_s1;
	logic [1:0] rp_s1;
	logic [AW-1:0] ri_s1;
	cand_t cand;
	logic [AW-1:0] cand_idx;
	logic [15:0] cand_spd;
	logic in_acc, wr_en;
	logic [AW-1:0] nxt_rd;
	logic [32:0] prod_sh;
	logic [IdxW-1:0] lai_o, nri_o;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign wr_en = in_acc && in_data.action == ACT_APPEND && count_q < DEPTH_C;
	assign rd_vld = (state_q == ST_SCAN);
	assign rd_first = first_q;
	assign rd_last = (left_q == CW'(1));
	assign nxt_rd = (CW'(rd_q) + CW'(1) >= n_q) ? '0 : AW'(CW'(rd_q) + CW'(1));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[count_q[AW-1:0]] <= in_data.coord_x;
			mem_y[count_q[AW-1:0]] <= in_data.coord_y;
			mem_s[count_q[AW-1:0]] <= in_data.speed;
		end
		rx_s1 <= mem_x[rd_q];
		ry_s1 <= mem_y[rd_q];
		rs_s1 <= mem_s[rd_q];
		ri_s1 <= rd_q;
		rp_s1 <= pass_q;
		rf_s1 <= rd_first;
		rl_s1 <= rd_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
		end else begin
			rv_s1 <= rd_vld;
		end
	end

	lws_dist #(.AW(AW)) u_dist (
		.clk, .arst_n,
		.vld(rv_s1), .first(rf_s1), .last(rl_s1), .pass(rp_s1), .idx(ri_s1),
		.px(signed'(rx_s1)), .py(signed'(ry_s1)), .cx(cx_q), .cy(cy_q), .spd(rs_s1),
		.cand, .cand_idx, .cand_spd
	);

	assign prod_sh = 33'(prod_q >> 8);
	always_comb begin
		la = prod_sh;
		if (la < 33'(min_q)) la = 33'(min_q);
		if (la > 33'(max_q)) la = 33'(max_q);
	end

	// clamped lookahead never exceeds max_q, so 24 bits carry it
	assign la_sq = 48'(la[23:0]) * 48'(la[23:0]);

	assign lai_o = IdxW'(lai_q);
	assign nri_o = IdxW'(nri_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q <= 24'd32768;
			max_q <= 24'd65536;
			slope_q <= 24'd8192;
			count_q <= '0;
			pos_q <= '0;
			out_valid <= 1'b0;
			first_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (reg_idx_t'(cfg_index))
					REG_MIN:   min_q <= cfg_data;
					REG_MAX:   max_q <= cfg_data;
					REG_SLOPE: slope_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						unique case (action_t'(in_data.action))
							ACT_APPEND: if (wr_en) count_q <= count_q + CW'(1);
							ACT_CLEAR: begin
								count_q <= '0;
								pos_q <= '0;
							end
							ACT_QUERY: begin
								cx_q <= in_data.coord_x;
								cy_q <= in_data.coord_y;
								n_q <= count_q;
								prod_q <= 40'(in_data.speed) * 40'(slope_q);
								if (count_q == '0) begin
									lai_q <= '0;
									nri_q <= '0;
									nrs_q <= '0;
									whit_q <= 1'b0;
									ahit_q <= 1'b0;
									out_valid <= 1'b1;
									state_q <= ST_OUT;
								end else begin
									state_q <= ST_MUL;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL: begin
					lasq_q <= 64'(la_sq);
					longest_q <= '0;
					whit_q <= 1'b0;
					ahit_q <= 1'b0;
					lai_q <= '0;
					pass_q <= PASS_WIN;
					rd_q <= (CW'(pos_q) < n_q) ? pos_q : '0;
					left_q <= (n_q < WIN_C) ? n_q : WIN_C;
					first_q <= 1'b1;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					first_q <= 1'b0;
					rd_q <= nxt_rd;
					left_q <= left_q - CW'(1);
					if (rd_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (cand.vld && cand.last) begin
						first_q <= 1'b1;
						rd_q <= '0;
						left_q <= n_q;
						if (cand.pass == PASS_WIN && !(whit_q ||
								(cand.dsq <= lasq_q && cand.dsq >= longest_q))) begin
							pass_q <= PASS_FULL;
							state_q <= ST_SCAN;
						end else if (cand.pass != PASS_NEAR) begin
							pass_q <= PASS_NEAR;
							state_q <= ST_SCAN;
						end else begin
							out_valid <= 1'b1;
							state_q <= ST_OUT;
						end
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						pos_q <= lai_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cand.vld) begin
				if (cand.pass == PASS_NEAR) begin
					if (cand.first || cand.dsq <= shortest_q) begin
						shortest_q <= cand.dsq;
						nri_q <= cand_idx;
						nrs_q <= cand_spd;
					end
				end else if (cand.dsq <= lasq_q && cand.dsq >= longest_q) begin
					longest_q <= cand.dsq;
					lai_q <= cand_idx;
					ahit_q <= 1'b1;
					if (cand.pass == PASS_WIN) whit_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		out_data.lookahead_index = lai_o;
		out_data.nearest_index = nri_o;
		out_data.nearest_speed = nrs_q;
		out_data.window_hit = whit_q;
		out_data.any_hit = ahit_q;
	end

	`ASSERT_IMPL(a_hit_order, clk, arst_n, out_valid, !out_data.window_hit || out_data.any_hit)
	`ASSERT_IMPL(a_busy_stall, clk, arst_n, out_valid, in_stall)
	`ASSERT_NEXT(a_cnt_cap, clk, arst_n, 1'b1, count_q <= DEPTH_C)

endmodule

[sim/lookahead_waypoint_search_tb.sv]
`timescale 1ns / 100ps

module lookahead_waypoint_search_tb;
	import lws_pkg::*;

	localparam int DEPTH  = 1024;
	localparam int WINDOW = 40;
	localparam int N_RANDOM = 270;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	lookahead_waypoint_search #(.DEPTH(DEPTH), .WINDOW(WINDOW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// predictor state
	logic signed [31:0] wp_x [DEPTH];
	logic signed [31:0] wp_y [DEPTH];
	logic [15:0]        wp_speed [DEPTH];
	int unsigned        wp_count;
	int unsigned        track_pos;
	logic [23:0]        la_min, la_max, la_slope;

	in_item_t  pending_beats [$];
	out_item_t expected_fixes [$];
	int        errors;
	int        n_queries, n_window_hits, n_fallbacks, n_fixes_seen;

	function automatic logic [63:0] range_sq(int unsigned i, logic signed [31:0] cx,
		logic signed [31:0] cy);
		logic signed [33:0] dx, dy;
		logic [63:0] sx, sy;
		logic [64:0] s;
		dx = 34'(wp_x[i]) - 34'(cx);
		dy = 34'(wp_y[i]) - 34'(cy);
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		sx = 64'(dx) * 64'(dx);
		sy = 64'(dy) * 64'(dy);
		s = 65'(sx) + 65'(sy);
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	task automatic apply_beat(in_item_t b);
		logic [63:0] la, la_sq, longest, d, shortest;
		int unsigned n, start, scan, i, pick, near_i;
		bit whit, ahit;
		out_item_t r;
		unique case (action_t'(b.action))
			ACT_APPEND: begin
				if (wp_count < DEPTH) begin
					wp_x[wp_count] = b.coord_x;
					wp_y[wp_count] = b.coord_y;
					wp_speed[wp_count] = b.speed;
					wp_count++;
				end
			end
			ACT_CLEAR: begin
				wp_count = 0;
				track_pos = 0;
			end
			ACT_QUERY: begin
				n_queries++;
				n = wp_count;
				r = '0;
				if (n != 0) begin
					la = (64'(b.speed) * 64'(la_slope)) >> 8;
					if (la < 64'(la_min)) la = 64'(la_min);
					if (la > 64'(la_max)) la = 64'(la_max);
					la_sq = la * la;
					longest = 0;
					pick = 0;
					whit = 0;
					start = track_pos < n ? track_pos : 0;
					scan = WINDOW < n ? WINDOW : n;
					i = start;
					for (int k = 0; k < scan; k++) begin
						d = range_sq(i, b.coord_x, b.coord_y);
						if (d <= la_sq && d >= longest) begin
							longest = d;
							pick = i;
							whit = 1;
						end
						i++;
						if (i >= n) i = 0;
					end
					ahit = whit;
					if (!whit) begin
						pick = 0;
						for (i = 0; i < n; i++) begin
							d = range_sq(i, b.coord_x, b.coord_y);
							if (d <= la_sq && d >= longest) begin
								longest = d;
								pick = i;
								ahit = 1;
							end
						end
					end
					shortest = range_sq(0, b.coord_x, b.coord_y);
					near_i = 0;
					for (i = 0; i < n; i++) begin
						d = range_sq(i, b.coord_x, b.coord_y);
						if (d <= shortest) begin
							shortest = d;
							near_i = i;
						end
					end
					track_pos = pick;
					r.lookahead_index = pick[IdxW-1:0];
					r.nearest_index = near_i[IdxW-1:0];
					r.nearest_speed = wp_speed[near_i];
					r.window_hit = whit;
					r.any_hit = ahit;
					if (whit) n_window_hits++;
					else n_fallbacks++;
				end
				expected_fixes = {expected_fixes, r};
			end
			default: ;
		endcase
	endtask

	// driver
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				apply_beat(in_data);
			end
			if (!in_valid || !in_stall) begin
				if (in_gap > 0 || pending_beats.size() == 0) begin
					in_valid <= 1'b0;
					if (in_gap > 0) in_gap <= in_gap - 1;
				end else begin
					in_valid <= 1'b1;
					in_data <= pending_beats.pop_front();
					in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
				end
			end
		end
	end

	// monitor
	int out_wait;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_wait <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				n_fixes_seen++;
				if (expected_fixes.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					errors++;
				end else begin
					out_item_t e;
					e = expected_fixes.pop_front();
					if (e.lookahead_index !== out_data.lookahead_index)
						$display("%0t: lookahead_index exp %0d got %0d", $time,
							e.lookahead_index, out_data.lookahead_index);
					if (e.nearest_index !== out_data.nearest_index)
						$display("%0t: nearest_index exp %0d got %0d", $time,
							e.nearest_index, out_data.nearest_index);
					if (e.nearest_speed !== out_data.nearest_speed)
						$display("%0t: nearest_speed exp %h got %h", $time,
							e.nearest_speed, out_data.nearest_speed);
					if (e.window_hit !== out_data.window_hit)
						$display("%0t: window_hit exp %b got %b", $time,
							e.window_hit, out_data.window_hit);
					if (e.any_hit !== out_data.any_hit)
						$display("%0t: any_hit exp %b got %b", $time,
							e.any_hit, out_data.any_hit);
					if (e !== out_data) errors++;
				end
				out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
				out_stall <= 1'b0;
			end else if (out_wait > 0) begin
				out_stall <= 1'b1;
				out_wait <= out_wait - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push(action_t a, logic signed [31:0] x, logic signed [31:0] y,
		logic [15:0] s);
		in_item_t b;
		b.action = a;
		b.coord_x = x;
		b.coord_y = y;
		b.speed = s;
		pending_beats = {pending_beats, b};
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0 || in_valid || expected_fixes.size() != 0)
			@(posedge clk);
		repeat (2200) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [23:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MIN:   la_min = v;
			REG_MAX:   la_max = v;
			REG_SLOPE: la_slope = v;
			default: ;
		endcase
	endtask

	// a track near a random point, so lookahead hits are common
	task automatic push_track(int len);
		logic signed [31:0] bx, by;
		bx = $urandom_range(0, 1) ? $signed($urandom) : $signed($urandom_range(0, 800000));
		by = $urandom_range(0, 1) ? $signed($urandom) : $signed($urandom_range(0, 800000));
		for (int k = 0; k < len; k++)
			push(ACT_APPEND, bx + $signed($urandom_range(0, 40000)) * k / 8,
				by + $signed($urandom_range(0, 40000)) - 20000, 16'($urandom));
	endtask

	task automatic push_random(int count);
		int k;
		k = 0;
		while (k < count) begin
			int r, len;
			logic signed [31:0] x, y;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				len = $urandom_range(1, 30);
				push(ACT_CLEAR, $signed($urandom), $signed($urandom), 16'($urandom));
				push_track(len);
				k += len + 1;
			end else if (r < 30) begin
				push(ACT_APPEND, $signed($urandom), $signed($urandom), 16'($urandom));
				k++;
			end else if (r < 33) begin
				push(ACT_NONE, $signed($urandom), $signed($urandom), 16'($urandom));
				k++;
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					x = $signed($urandom_range(0, 800000));
					y = $signed($urandom_range(0, 800000));
				end else begin
					x = $signed($urandom);
					y = $signed($urandom);
				end
				push(ACT_QUERY, x, y, 16'($urandom));
				k++;
			end
		end
	endtask

	initial begin
		errors = 0;
		n_queries = 0;
		n_window_hits = 0;
		n_fallbacks = 0;
		n_fixes_seen = 0;
		wp_count = 0;
		track_pos = 0;
		la_min = 24'd32768;
		la_max = 24'd65536;
		la_slope = 24'd8192;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		push(ACT_QUERY, 32'sd0, 32'sd0, 16'd0);
		push(ACT_APPEND, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'hFFFF);
		push(ACT_APPEND, -32'sh8000_0000, -32'sh8000_0000, 16'h0000);
		push(ACT_QUERY, 32'sh7FFF_FFFF, -32'sh8000_0000, 16'hFFFF);
		push(ACT_QUERY, 32'sd0, 32'sd0, 16'h0000);
		push(ACT_NONE, 32'sd5, 32'sd5, 16'd5);
		push(ACT_APPEND, 32'sd0, 32'sd0, 16'h1234);
		push(ACT_APPEND, 32'sd0, 32'sd0, 16'h5678);
		push(ACT_APPEND, 32'sd30000, 32'sd0, 16'h00AA);
		push(ACT_QUERY, 32'sd0, 32'sd0, 16'h0100);
		push(ACT_QUERY, -32'sd100000, 32'sd0, 16'h0100);
		push(ACT_CLEAR, 32'sd0, 32'sd0, 16'd0);
		push(ACT_QUERY, 32'sd0, 32'sd0, 16'd0);
		push_track(50);
		push(ACT_QUERY, 32'sd0, 32'sd0, 16'hFFFF);
		push(ACT_QUERY, -32'sd1, -32'sd1, 16'h8000);
		wait_drained();

		// larger table, wide lookahead
		write_reg(REG_MAX, 24'hFF_FFFF);
		write_reg(REG_SLOPE, 24'hFF_FFFF);
		push(ACT_CLEAR, 32'sd0, 32'sd0, 16'd0);
		for (int k = 0; k < 200; k++)
			push(ACT_APPEND, $signed($urandom_range(0, 4000000)),
				$signed($urandom_range(0, 4000000)), 16'($urandom));
		for (int k = 0; k < 4; k++)
			push(ACT_QUERY, $signed($urandom_range(0, 4000000)),
				$signed($urandom_range(0, 4000000)), 16'($urandom));
		push(ACT_CLEAR, 32'sd0, 32'sd0, 16'd0);
		push_track(30);
		push_random(60);
		wait_drained();

		// min above max
		write_reg(REG_MIN, 24'hFF_FFFF);
		write_reg(REG_MAX, 24'd20000);
		write_reg(REG_SLOPE, 24'd0);
		push_random(60);
		wait_drained();

		write_reg(REG_MIN, 24'd0);
		write_reg(REG_MAX, 24'd0);
		push_random(40);
		wait_drained();

		write_reg(REG_MIN, 24'd1000);
		write_reg(REG_MAX, 24'd300000);
		write_reg(REG_SLOPE, 24'd40000);
		push_random(N_RANDOM - 160);
		wait_drained();

		$display("queries %0d: %0d window hits, %0d fell back; %0d results checked",
			n_queries, n_window_hits, n_fallbacks, n_fixes_seen);
		if (errors == 0 && expected_fixes.size() == 0) begin
			$display("lookahead_waypoint_search test passed");
		end else begin
			$display("lookahead_waypoint_search test failed");
		end
		$finish;
	end

	initial begin
		#100ms;
		$display("lookahead_waypoint_search test failed");
		$finish;
	end

endmodule
